/* rtl/core/flooding_node_table_update_core_defines.svh */
// Assertion macros for the flooding node table update core.
// No dependencies; included by the RTL files that carry checks.
`ifndef FLOODING_NODE_TABLE_UPDATE_CORE_DEFINES_SVH
`define FLOODING_NODE_TABLE_UPDATE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// plain property, sampled on clk, muted during reset
`define FNTU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication: cons must hold whenever ante holds
`define FNTU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define FNTU_ASSERT(lbl, prop, msg)
`define FNTU_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/fntu_pkg.sv */
// Types and constants for the flooding node table update core.
// No dependencies.
package fntu_pkg;

  localparam int ID_W       = 64;
  localparam int SEQ_W      = 16;
  localparam int TAG_W      = 64;
  localparam int OUTCOME_W  = 3;
  localparam int OUT_IDX_W  = 6;
  localparam int OUT_TOT_W  = 7;
  localparam int IN_TDATA_W  = 144;  // 64 + 16 + 64, already whole bytes
  localparam int OUT_TDATA_W = 32;   // 3 + 6 + 7 + 16

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_INSERTED = 3'd0,
    OUT_REPLACED = 3'd1,
    OUT_STALE    = 3'd2,
    OUT_BUMPED   = 3'd3,
    OUT_OWNKEPT  = 3'd4,
    OUT_FULL     = 3'd5
  } fntu_outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } fntu_state_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SEQ_W-1:0] seq;
    logic [TAG_W-1:0] tag;
  } fntu_entry_t;

  // a is serially at most b (mod 2^16)
  function automatic logic serial_le(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] diff;
    diff = b - a;
    return !diff[SEQ_W-1];
  endfunction

endpackage

/* rtl/core/flooding_node_table_update_core.sv */
// Flooding node table update core: top level.
// Depends on fntu_pkg and flooding_node_table_update_core_defines.svh.
//
// Usage:
//   in_*  : one transfer per announced node state. in_tdata holds, from bit 0:
//           node_id[63:0], node_seqno[15:0], data_tag[63:0].
//   out_* : one transfer per accepted item. out_tdata holds, from bit 0:
//           outcome[2:0], entry_index[5:0], entry_total[6:0], own_seqno_out[15:0].
//   cfg_* : write own_id while the core is idle; no read-back.
// The table lives in one synchronous RAM (one write port, one registered read
// port). An announcement of our own id, or any id while the table is empty,
// skips the scan and goes straight from accept to the decide step.
// Any other id is looked up by a linear scan, one entry read per cycle: the
// registered RAM read of each slot is compared with the item id; the scan ends
// on a match or at the last slot below the count.
// One item is in flight at a time.
// Reset clears the entry count, our own sequence number and own_id; RAM
// contents are not cleared, only slots below the count are ever compared.
// A stalled receiver holds the result in the output register; the core waits
// in its decide step and commits table updates only when the result moves.
module flooding_node_table_update_core #(
  parameter int ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // cfg
  input  logic                            cfg_wr_en,
  input  logic [63:0]                     cfg_wr_data,   // own_id
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fntu_pkg::IN_TDATA_W-1:0] in_tdata,      // node_id, node_seqno, data_tag
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fntu_pkg::OUT_TDATA_W-1:0] out_tdata     // outcome, entry_index,
                                                         // entry_total, own_seqno_out
);
  import fntu_pkg::*;
`include "flooding_node_table_update_core_defines.svh"

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // ---------------- state ----------------
  fntu_state_t       state_r, state_nxt;
  logic [ID_W-1:0]   own_id_r;
  logic [SEQ_W-1:0]  own_seqno_r, own_seqno_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // latched item
  logic [ID_W-1:0]   item_id_r;
  logic [SEQ_W-1:0]  item_seq_r;
  logic [TAG_W-1:0]  item_tag_r;
  logic              own_r;

  // scan pipeline
  logic [CNT_W-1:0]  issue_idx_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              found_r;
  logic [IDX_W-1:0]  slot_r;
  logic [SEQ_W-1:0]  hit_seq_r;

  // table RAM
  fntu_entry_t       mem [ENTRIES];
  fntu_entry_t       rd_data_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  fntu_entry_t       mem_wdata;

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // ---------------- control terms ----------------
  logic in_xfer;
  logic out_free;
  logic issue_vld;
  logic scan_hit;
  logic scan_last;
  logic in_is_own;

  fntu_outcome_t    outcome;
  logic [IDX_W-1:0] res_slot;

  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_is_own = (in_tdata[ID_W-1:0] == own_id_r);
  assign issue_vld = (issue_idx_r < count_r);
  assign scan_hit  = cmp_vld_r && (rd_data_r.id == item_id_r);
  assign scan_last = cmp_vld_r && ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == count_r);

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          // own id or empty table: nothing to scan
          state_nxt = (in_is_own || count_r == '0) ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_last) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- decide / outputs ----------------
  always_comb begin
    in_tready     = 1'b0;
    outcome       = OUT_FULL;
    res_slot      = '0;
    mem_we        = 1'b0;
    mem_waddr     = slot_r;
    mem_wdata     = '{id: item_id_r, seq: item_seq_r, tag: item_tag_r};
    own_seqno_nxt = own_seqno_r;
    count_nxt     = count_r;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_SCAN: ;
      ST_DECIDE: begin
        if (own_r) begin
          if (serial_le(own_seqno_r, item_seq_r)) begin
            outcome       = OUT_BUMPED;
            own_seqno_nxt = item_seq_r + SEQ_W'(1);
          end else begin
            outcome = OUT_OWNKEPT;
          end
        end else if (found_r) begin
          res_slot = slot_r;
          if (!serial_le(item_seq_r, hit_seq_r)) begin
            outcome = OUT_REPLACED;
            mem_we  = out_free;
          end else begin
            outcome = OUT_STALE;
          end
        end else if (count_r != CNT_W'(ENTRIES)) begin
          outcome   = OUT_INSERTED;
          res_slot  = count_r[IDX_W-1:0];
          mem_waddr = count_r[IDX_W-1:0];
          mem_we    = out_free;
          count_nxt = count_r + CNT_W'(1);
        end else begin
          outcome = OUT_FULL;
        end
      end
      default: ;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      own_id_r    <= '0;
      own_seqno_r <= '0;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) own_id_r <= cfg_wr_data;

      if (state_r == ST_DECIDE && out_free) begin
        own_seqno_r <= own_seqno_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == ST_SCAN && !(scan_hit || scan_last)) begin
        cmp_vld_r <= issue_vld;
      end else begin
        cmp_vld_r <= 1'b0;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_id_r   <= in_tdata[ID_W-1:0];
      item_seq_r  <= in_tdata[ID_W +: SEQ_W];
      item_tag_r  <= in_tdata[ID_W+SEQ_W +: TAG_W];
      own_r       <= in_is_own;
      found_r     <= 1'b0;
      issue_idx_r <= '0;
    end else if (state_r == ST_SCAN) begin
      if (issue_vld) issue_idx_r <= issue_idx_r + CNT_W'(1);
      cmp_idx_r <= issue_idx_r[IDX_W-1:0];
      if (scan_hit) begin
        found_r   <= 1'b1;
        slot_r    <= cmp_idx_r;
        hit_seq_r <= rd_data_r.seq;
      end
    end
    if (state_r == ST_DECIDE && out_free) begin
      out_data_r <= {own_seqno_nxt, OUT_TOT_W'(count_nxt), OUT_IDX_W'(res_slot), outcome};
    end
  end

  // ---------------- table RAM ----------------
  // Writes only happen in the decide step; the next scan starts only after the
  // idle state accepts a new item, so a read never overlaps a write to the same slot.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[issue_idx_r[IDX_W-1:0]];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------- checks ----------------
  `FNTU_ASSERT(a_count_bound, count_r <= CNT_W'(ENTRIES), "entry count above table size")
  `FNTU_ASSERT_IMP(a_we_decide, mem_we,
    state_r == ST_DECIDE && out_free && !own_r, "table write outside decide")
  `FNTU_ASSERT_IMP(a_count_step, count_r != $past(count_r),
    count_r == $past(count_r) + CNT_W'(1) && out_tvalid,
    "entry count moved by other than one insert")
  `FNTU_ASSERT_IMP(a_cmp_range, cmp_vld_r, CNT_W'(cmp_idx_r) < count_r,
    "scan compared a slot beyond count")
  `FNTU_ASSERT_IMP(a_own_bump, own_seqno_r != $past(own_seqno_r),
    out_tvalid && out_tdata[OUTCOME_W-1:0] == OUT_BUMPED,
    "own seqno changed without bump result")

endmodule
